// ===== rtl/touch_event_to_pointer_mapper_assert.svh =====
// Assertion helpers shared by the mapper RTL.
`ifndef TOUCH_EVENT_TO_POINTER_MAPPER_ASSERT_SVH
`define TOUCH_EVENT_TO_POINTER_MAPPER_ASSERT_SVH

// Property checked every clock edge outside reset.
`define TEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define TEM_ASSERT_IMP(lbl, ante, cons, msg) \
  `TEM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/tem_pkg.sv =====
`default_nettype none

package tem_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SENSOR_X_MAX  = 3'd0;
  localparam logic [2:0] CFG_SENSOR_Y_MAX  = 3'd1;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_ORIENTATION   = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_SENSOR_X_MAX  = 16'd1080;
  localparam logic [15:0] RST_SENSOR_Y_MAX  = 16'd2264;
  localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd1080;
  localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd2264;

  // Event classes and codes
  localparam logic [15:0] EV_KEY     = 16'd1;
  localparam logic [15:0] EV_ABS     = 16'd3;
  localparam logic [15:0] CODE_POS_X = 16'd53;
  localparam logic [15:0] CODE_POS_Y = 16'd54;
  localparam logic [15:0] CODE_SLOT  = 16'd47;
  localparam logic [15:0] CODE_TRACK = 16'd57;
  localparam logic [15:0] CODE_TOUCH = 16'd330;

  // Serial divider step counts
  localparam logic [5:0] DIV_STEPS_RATIO = 6'd16;
  localparam logic [5:0] DIV_STEPS_POS   = 6'd32;

  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } act_e;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic [30:0]        event_seconds;
  } evt_t;

  typedef struct packed {
    act_e               pointer_action;
    logic signed [31:0] pointer_x;
    logic signed [31:0] pointer_y;
  } ptr_t;

  // Divider start request
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
    logic [5:0]  steps;
  } div_req_t;

  // Axis lane start request
  typedef struct packed {
    logic               start;
    logic               mirror;
    logic signed [31:0] raw;
    logic [15:0]        full;
    logic [15:0]        size;
  } lane_req_t;

endpackage

`default_nettype wire

// ===== rtl/tem_if.sv =====
`default_nettype none

// Touch event channel
interface tem_evt_if;
  import tem_pkg::*;
  logic valid;
  logic ready;
  evt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Pointer action channel
interface tem_ptr_if;
  import tem_pkg::*;
  logic valid;
  logic ready;
  ptr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tem_sdiv.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend shifts out of
// the top of quo_q while quotient bits shift in at the bottom.
module tem_sdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tem_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic [31:0]         quo_o
);
  import tem_pkg::*;

  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [16:0] trial;
  logic [16:0] diff;

  // One trial subtraction per step
  always_comb begin
    trial  = {rem_q, quo_q[31]};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
      if (!diff[16]) begin
        rem_d = diff[15:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/tem_axis.sv =====
`default_nettype none

// One axis: ratio = full / size, then |raw| / ratio, then sign and mirror.
module tem_axis (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tem_pkg::lane_req_t  req_i,
  output logic                done_o,
  output logic [31:0]         res_o
);
  import tem_pkg::*;

  typedef enum logic [2:0] {
    LN_IDLE  = 3'b001,
    LN_RATIO = 3'b010,
    LN_POS   = 3'b100
  } lane_st_e;

  lane_st_e    st_q, st_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic        mirror_q, mirror_d;
  logic [31:0] mag_q, mag_d;
  logic [15:0] size_q, size_d;
  logic [31:0] res_q, res_d;
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] quo;
  logic [15:0] ratio;
  logic [31:0] raw_u;
  logic [31:0] addend;
  logic [31:0] base;

  tem_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // Zero ratio or zero screen size divide by one
  assign ratio = ((size_q == '0) || (quo[15:0] == '0)) ? 16'd1 : quo[15:0];
  assign raw_u = $unsigned(req_i.raw);

  // Fold sign and mirror into a single add
  assign addend = (mirror_q ^ neg_q) ? (~quo + 32'd1) : quo;
  assign base   = mirror_q ? {16'h0, size_q} : 32'h0;

  always_comb begin
    st_d     = st_q;
    done_d   = 1'b0;
    neg_d    = neg_q;
    mirror_d = mirror_q;
    mag_d    = mag_q;
    size_d   = size_q;
    res_d    = res_q;
    div_req  = '0;
    unique case (st_q)
      LN_IDLE: begin
        if (req_i.start) begin
          div_req.start = 1'b1;
          div_req.num   = {req_i.full, 16'h0};
          div_req.den   = req_i.size;
          div_req.steps = DIV_STEPS_RATIO;
          neg_d         = req_i.raw[31];
          mag_d         = req_i.raw[31] ? (~raw_u + 32'd1) : raw_u;
          mirror_d      = req_i.mirror;
          size_d        = req_i.size;
          st_d          = LN_RATIO;
        end
      end
      LN_RATIO: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.num   = mag_q;
          div_req.den   = ratio;
          div_req.steps = DIV_STEPS_POS;
          st_d          = LN_POS;
        end
      end
      LN_POS: begin
        if (div_done) begin
          res_d  = base + addend;
          done_d = 1'b1;
          st_d   = LN_IDLE;
        end
      end
      default: st_d = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LN_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    mirror_q <= mirror_d;
    mag_q    <= mag_d;
    size_q   <= size_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/touch_event_to_pointer_mapper.sv =====
// A Y-position beat starts both axis lanes; its move beat is loaded once they finish
// and the output is free. A click appears in the cycle after its beat is accepted.
// Input stalls until the move is loaded, over two bit-serial divisions per axis
// (16-bit ratio, then 32-bit quotient), both axes in parallel.
// Reset: registers return to their defaults, tracked touch state clears, the
// output register empties.
`default_nettype none
`include "touch_event_to_pointer_mapper_assert.svh"

module touch_event_to_pointer_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tem_evt_if.sink     evt_i,
  tem_ptr_if.source   ptr_o
);
  import tem_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } st_e;

  st_e         st_q, st_d;
  logic [15:0] sens_x_q, sens_y_q, scr_w_q, scr_h_q;
  logic [2:0]  orient_q;
  logic [31:0] raw_x_q;
  logic        slot_q, lifted_q, hold_q;
  logic [30:0] press_q;
  logic        out_valid_q, out_valid_d;
  ptr_t        out_q, out_d;

  logic        in_fire, out_free;
  logic        is_abs, is_touch, is_y;
  logic        val_one, val_zero, val_neg1;
  logic [31:0] held;
  logic        held_short, held_mid, click;
  logic        load_move, load_click;
  logic        out_click;
  lane_req_t   x_req, y_req;
  logic        x_done, y_done;
  logic [31:0] x_res, y_res;

  // Beat decode
  assign in_fire  = evt_i.valid && evt_i.ready;
  assign out_free = !out_valid_q || ptr_o.ready;
  assign is_abs   = (evt_i.data.event_type == EV_ABS);
  assign is_touch = (evt_i.data.event_type == EV_KEY) && (evt_i.data.event_code == CODE_TOUCH);
  assign is_y     = is_abs && (evt_i.data.event_code == CODE_POS_Y);
  assign val_one  = (evt_i.data.event_value == 32'sd1);
  assign val_zero = (evt_i.data.event_value == 32'sd0);
  assign val_neg1 = (evt_i.data.event_value == -32'sd1);

  // Press duration, signed
  assign held       = {1'b0, evt_i.data.event_seconds} - {1'b0, press_q};
  assign held_short = held[31] || (held == 32'd0);
  assign held_mid   = (held == 32'd1) || (held == 32'd2);
  assign click      = is_touch && val_zero && (held_short || held_mid);

  assign evt_i.ready = (st_q == ST_IDLE) && out_free;

  // Axis lanes
  always_comb begin
    x_req.start  = in_fire && is_y;
    x_req.mirror = orient_q[0];
    x_req.raw    = $signed(raw_x_q);
    x_req.full   = sens_x_q;
    x_req.size   = scr_w_q;
    y_req.start  = in_fire && is_y;
    y_req.mirror = orient_q[1];
    y_req.raw    = evt_i.data.event_value;
    y_req.full   = sens_y_q;
    y_req.size   = scr_h_q;
  end

  tem_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (x_req),
    .done_o (x_done),
    .res_o  (x_res)
  );

  tem_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (y_req),
    .done_o (y_done),
    .res_o  (y_res)
  );

  // Sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_fire && is_y) st_d = ST_CALC;
      ST_CALC: if (x_done) st_d = ST_EMIT;
      ST_EMIT: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Output register
  assign load_move  = (st_q == ST_EMIT) && out_free;
  assign load_click = in_fire && click;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !ptr_o.ready;
    if (load_move) begin
      out_d.pointer_action = hold_q ? ACT_HOLD : ACT_MOVE;
      out_d.pointer_x      = $signed(orient_q[2] ? y_res : x_res);
      out_d.pointer_y      = $signed(orient_q[2] ? x_res : y_res);
      out_valid_d          = 1'b1;
    end else if (load_click) begin
      out_d.pointer_action = held_short ? ACT_LEFT : ACT_RIGHT;
      out_d.pointer_x      = '0;
      out_d.pointer_y      = '0;
      out_valid_d          = 1'b1;
    end
  end

  assign ptr_o.valid = out_valid_q;
  assign ptr_o.data  = out_q;

  // Click beat on the output
  assign out_click = (ptr_o.data.pointer_action == ACT_LEFT) ||
                     (ptr_o.data.pointer_action == ACT_RIGHT);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_x_q <= RST_SENSOR_X_MAX;
      sens_y_q <= RST_SENSOR_Y_MAX;
      scr_w_q  <= RST_SCREEN_WIDTH;
      scr_h_q  <= RST_SCREEN_HEIGHT;
      orient_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_X_MAX:  sens_x_q <= cfg_data_i;
        CFG_SENSOR_Y_MAX:  sens_y_q <= cfg_data_i;
        CFG_SCREEN_WIDTH:  scr_w_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: scr_h_q  <= cfg_data_i;
        CFG_ORIENTATION:   orient_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Touch tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_x_q  <= '0;
      slot_q   <= 1'b0;
      lifted_q <= 1'b0;
      press_q  <= '0;
      hold_q   <= 1'b0;
    end else if (in_fire) begin
      if (is_abs && (evt_i.data.event_code == CODE_POS_X)) begin
        raw_x_q <= $unsigned(evt_i.data.event_value);
      end
      if (is_abs && (evt_i.data.event_code == CODE_SLOT)) begin
        slot_q <= val_one;
      end
      if (is_abs && (evt_i.data.event_code == CODE_TRACK)) begin
        lifted_q <= val_neg1;
      end
      if (is_y) begin
        hold_q <= slot_q && !lifted_q;
      end
      if (is_touch && val_one) begin
        press_q <= evt_i.data.event_seconds;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Checks
  `TEM_ASSERT(a_lanes_in_step, x_done == y_done, "axis lanes finished out of step")
  `TEM_ASSERT_IMP(a_done_in_calc, x_done, st_q == ST_CALC, "lane result outside calc state")
  `TEM_ASSERT_IMP(a_click_zero_xy, ptr_o.valid && out_click, ptr_o.data.pointer_x == 32'sd0 && ptr_o.data.pointer_y == 32'sd0, "click beat with nonzero xy")
  `TEM_ASSERT_IMP(a_no_click_while_busy, load_click, st_q == ST_IDLE, "click loaded while busy")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  import tem_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tem_evt_if evt_if ();
  tem_ptr_if ptr_if ();

  touch_event_to_pointer_mapper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .ptr_o      (ptr_if)
  );

  // Tracks touch state and settings, predicts each pointer beat, checks it
  class pointer_tracker;
    longint    sensor_x, sensor_y, width, height;
    bit [2:0]  orient;
    int        raw_x, raw_y;
    bit        slot_one, lifted;
    bit [30:0] press_sec;
    ptr_t      pending_ptr_q[$];
    int        errors, moves, clicks;

    function new();
      sensor_x  = longint'(RST_SENSOR_X_MAX);
      sensor_y  = longint'(RST_SENSOR_Y_MAX);
      width     = longint'(RST_SCREEN_WIDTH);
      height    = longint'(RST_SCREEN_HEIGHT);
      orient    = '0;
      raw_x     = 0;
      raw_y     = 0;
      slot_one  = 1'b0;
      lifted    = 1'b0;
      press_sec = '0;
      errors    = 0;
      moves     = 0;
      clicks    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_SENSOR_X_MAX:  sensor_x = longint'(val);
        CFG_SENSOR_Y_MAX:  sensor_y = longint'(val);
        CFG_SCREEN_WIDTH:  width = longint'(val);
        CFG_SCREEN_HEIGHT: height = longint'(val);
        CFG_ORIENTATION:   orient = val[2:0];
        default: ;
      endcase
    endfunction

    // Truncating divide by sensor/screen ratio; zero ratio or size means 1
    function longint scaled(int raw, longint full, longint size);
      longint ratio;
      ratio = (size == 0) ? 1 : full / size;
      if (ratio == 0) ratio = 1;
      return longint'(raw) / ratio;
    endfunction

    function void note_event(evt_t e);
      ptr_t   want;
      longint sx, sy, ax, ay, now_s, then_s, held;
      want = '0;
      if (e.event_type == EV_ABS) begin
        case (e.event_code)
          CODE_POS_X: raw_x = e.event_value;
          CODE_POS_Y: raw_y = e.event_value;
          CODE_SLOT:  slot_one = (e.event_value == 32'sd1);
          CODE_TRACK: lifted = (e.event_value == -32'sd1);
          default: ;
        endcase
        if (e.event_code == CODE_POS_Y) begin
          sx = scaled(raw_x, sensor_x, width);
          sy = scaled(raw_y, sensor_y, height);
          ax = orient[0] ? width - sx : sx;
          ay = orient[1] ? height - sy : sy;
          want.pointer_action = (slot_one && !lifted) ? ACT_HOLD : ACT_MOVE;
          want.pointer_x = orient[2] ? ay[31:0] : ax[31:0];
          want.pointer_y = orient[2] ? ax[31:0] : ay[31:0];
          pending_ptr_q.push_back(want);
        end
      end else if (e.event_type == EV_KEY && e.event_code == CODE_TOUCH) begin
        if (e.event_value == 32'sd1) begin
          press_sec = e.event_seconds;
        end else if (e.event_value == 32'sd0) begin
          now_s  = longint'(e.event_seconds);
          then_s = longint'(press_sec);
          held   = now_s - then_s;
          // short (or negative) hold clicks left, 1..2 s clicks right, longer is dropped
          if (held < 1) begin
            want.pointer_action = ACT_LEFT;
            pending_ptr_q.push_back(want);
          end else if (held <= 2) begin
            want.pointer_action = ACT_RIGHT;
            pending_ptr_q.push_back(want);
          end
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_pointer(ptr_t got);
      ptr_t want;
      if (pending_ptr_q.size() == 0) begin
        report($sformatf("pointer beat with none pending: action %0d x %0d y %0d",
                         got.pointer_action, got.pointer_x, got.pointer_y));
        return;
      end
      want = pending_ptr_q.pop_front();
      if (got.pointer_action !== want.pointer_action)
        report($sformatf("action got %0d want %0d", got.pointer_action,
                         want.pointer_action));
      if (got.pointer_x !== want.pointer_x)
        report($sformatf("x got %0d want %0d", got.pointer_x, want.pointer_x));
      if (got.pointer_y !== want.pointer_y)
        report($sformatf("y got %0d want %0d", got.pointer_y, want.pointer_y));
      if (want.pointer_action == ACT_LEFT || want.pointer_action == ACT_RIGHT) clicks++;
      else moves++;
    endtask
  endclass

  pointer_tracker sb;
  int in_idle_pct;
  int out_stall_pct;
  int long_hold_req;
  int beats_sent;
  int noise_sent;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run guard
  initial begin
    #1200000;
    $display("TEST FAILED");
    $finish;
  end

  // Pointer sink: checks each beat, stalls at random, honors a long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    ptr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (ptr_if.valid && ptr_if.ready) sb.check_pointer(ptr_if.data);
      if (long_hold_req != 0) begin
        hold_left = 3000;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ptr_if.ready <= 1'b0;
      end else begin
        ptr_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // One event beat; valid stays high after accept until the caller lowers it
  task automatic send_event(input evt_t e);
    while ($urandom_range(99) < in_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid <= 1'b1;
    evt_if.data  <= e;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sb.note_event(e);
    beats_sent++;
  endtask

  task automatic send(input logic [15:0] ev_type, input logic [15:0] ev_code,
                      input int value, input bit [30:0] secs);
    evt_t e;
    e.event_type    = ev_type;
    e.event_code    = ev_code;
    e.event_value   = value;
    e.event_seconds = secs;
    send_event(e);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic [15:0] sxm, input logic [15:0] sym,
                             input logic [15:0] sw, input logic [15:0] sh,
                             input logic [2:0] ori);
    write_reg(CFG_SENSOR_X_MAX, sxm);
    write_reg(CFG_SENSOR_Y_MAX, sym);
    write_reg(CFG_SCREEN_WIDTH, sw);
    write_reg(CFG_SCREEN_HEIGHT, sh);
    write_reg(CFG_ORIENTATION, {13'd0, ori});
    cfg_we_i <= 1'b0;
  endtask

  // Wait out all pending beats plus the block's pipeline depth
  task automatic settle();
    while (sb.pending_ptr_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic int pick_raw(input longint full);
    case ($urandom_range(9))
      0: return $urandom();
      1: return -int'($urandom_range(1, 65535));
      2: return int'(full);
      default: return $urandom_range(0, int'(full));
    endcase
  endfunction

  // Beats the block should ignore or that exercise odd codes and values
  task automatic send_noise();
    case ($urandom_range(3))
      0: send(16'($urandom()), 16'($urandom()), $urandom(), 31'($urandom()));
      1: send(EV_ABS, 16'($urandom()), $urandom(), 31'($urandom()));
      2: send(EV_KEY, CODE_TOUCH, $urandom_range(2, 100), 31'($urandom()));
      default: send(EV_KEY, 16'($urandom()), $urandom(), 31'($urandom()));
    endcase
    noise_sent++;
  endtask

  // A touch gesture: slot/tracking setup, press, a few moves, release
  task automatic send_gesture();
    bit [30:0] t0;
    bit [30:0] t1;
    int        n;
    t0 = 31'($urandom());
    if ($urandom_range(7) == 0) t0 = 31'h7fff_ffff - 31'($urandom_range(3));
    if ($urandom_range(2) == 0)
      send(EV_ABS, CODE_SLOT, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1),
           31'($urandom()));
    if ($urandom_range(2) == 0)
      case ($urandom_range(2))
        0: send(EV_ABS, CODE_TRACK, -1, 31'($urandom()));
        1: send(EV_ABS, CODE_TRACK, $urandom_range(0, 100), 31'($urandom()));
        default: send(EV_ABS, CODE_TRACK, $urandom(), 31'($urandom()));
      endcase
    if ($urandom_range(4) != 0) send(EV_KEY, CODE_TOUCH, 1, t0);
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(3) != 0)
        send(EV_ABS, CODE_POS_X, pick_raw(sb.sensor_x), 31'($urandom()));
      send(EV_ABS, CODE_POS_Y, pick_raw(sb.sensor_y), 31'($urandom()));
      if ($urandom_range(9) == 0) send(EV_ABS, CODE_TRACK, -1, 31'($urandom()));
      if ($urandom_range(7) == 0) send_noise();
    end
    if ($urandom_range(5) != 0) begin
      t1 = t0 + 31'($urandom_range(6)) - 31'd2;
      send(EV_KEY, CODE_TOUCH, 0, t1);
    end
    if ($urandom_range(4) == 0) send_noise();
  endtask

  // Corners with the reset settings
  task automatic run_directed();
    send(EV_ABS, CODE_POS_X, 540, 0);
    send(EV_ABS, CODE_POS_Y, 1132, 0);
    send(EV_ABS, CODE_SLOT, 1, 0);
    send(EV_ABS, CODE_TRACK, 7, 0);
    send(EV_ABS, CODE_POS_Y, 0, 0);
    send(EV_ABS, CODE_TRACK, -1, 0);
    send(EV_ABS, CODE_POS_Y, 2264, 0);
    send(EV_ABS, CODE_POS_X, 32'h8000_0000, 31'h7fff_ffff);
    send(EV_ABS, CODE_POS_Y, 32'h7fff_ffff, 31'h7fff_ffff);
    send(EV_ABS, CODE_SLOT, 0, 0);
    // press/release timing: zero, one, two, three seconds, then backwards
    send(EV_KEY, CODE_TOUCH, 1, 100);
    send(EV_KEY, CODE_TOUCH, 0, 100);
    send(EV_KEY, CODE_TOUCH, 0, 101);
    send(EV_KEY, CODE_TOUCH, 0, 102);
    send(EV_KEY, CODE_TOUCH, 0, 103);
    send(EV_KEY, CODE_TOUCH, 0, 99);
    send(EV_KEY, CODE_TOUCH, 1, 31'h7fff_ffff);
    send(EV_KEY, CODE_TOUCH, 0, 0);
    // ignored beats
    send(EV_KEY, CODE_TOUCH, 2, 5);
    send(16'hffff, 16'hffff, -1, 31'h7fff_ffff);
    send(16'h0000, 16'h0000, 0, 0);
    send(EV_ABS, CODE_TOUCH, 1, 0);
    send(EV_KEY, CODE_POS_Y, 5, 0);
    evt_if.valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int in_idle_tab[8];
    int out_stall_tab[8];
    int start_beats;
    sb = new();
    in_idle_tab   = '{0, 78, 0, 31, 0, 78, 0, 31};
    out_stall_tab = '{0, 0, 78, 31, 0, 0, 78, 31};
    in_idle_pct   = 0;
    out_stall_pct = 0;
    long_hold_req = 0;
    beats_sent    = 0;
    noise_sent    = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SENSOR_X_MAX;
    cfg_data_i    <= '0;
    evt_if.valid  <= 1'b0;
    evt_if.data   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_directed();

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: apply_setup(16'hffff, 16'hffff, 16'd1, 16'd1, 3'd7);
        1: apply_setup(16'd1, 16'd1, 16'hffff, 16'hffff, 3'd3);
        2: apply_setup(RST_SENSOR_X_MAX, RST_SENSOR_Y_MAX, 16'd0, 16'd0, 3'd5);
        default: apply_setup(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
                             3'($urandom_range(7)));
      endcase
      in_idle_pct   = in_idle_tab[ph];
      out_stall_pct = out_stall_tab[ph];
      if (ph == 4) long_hold_req = 1;
      start_beats = beats_sent - noise_sent;
      while (beats_sent - noise_sent - start_beats < 125) send_gesture();
      evt_if.valid <= 1'b0;
    end

    settle();
    $display("Covered %0d event beats (%0d ignored noise) over 9 setting phases;",
             beats_sent, noise_sent);
    $display("checked %0d moves and %0d clicks, %0d mismatches.",
             sb.moves, sb.clicks, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
